// File: rtl/core/obra_pkg.sv
// Shared constants, types and helper functions of the octree restriction averager.
package obra_pkg;

	localparam int MAX_DIM = 16;
	localparam int MAX_VARS = 5;
	localparam int HALF_MAX = MAX_DIM / 2;
	localparam int SLOTS = HALF_MAX * HALF_MAX * MAX_VARS;
	localparam int SLOT_W = $clog2(SLOTS);

	localparam int CHILD_W = 3;
	localparam int FINE_W = 4;
	localparam int VAR_W = 3;
	localparam int SAMPLE_W = 32;
	localparam int SUM_W = SAMPLE_W + 3;
	localparam int TGT_W = 15;
	localparam int DIM_W = 5;
	localparam int OCT_BITS = 3;
	localparam int OCT_W = 8 * OCT_BITS;

	localparam int A_W = 8;
	localparam int B_W = 12;

	localparam int IN_BITS = CHILD_W + 3 * FINE_W + VAR_W + SAMPLE_W;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = TGT_W + SAMPLE_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = OCT_W;

	localparam logic [TGT_W-1:0] TGT_MAX = TGT_W'(MAX_DIM * MAX_DIM * MAX_DIM * MAX_VARS - 1);

	localparam logic [DIM_W-1:0] RST_DIM = DIM_W'(8);
	localparam logic [VAR_W-1:0] RST_VARS = VAR_W'(5);
	localparam logic [OCT_W-1:0] RST_OCT = OCT_W'(16434824);

	localparam logic [CFG_IDX_W-1:0] REG_DIM_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_OCTANT = CFG_IDX_W'(4);

	typedef struct packed {
		logic [DIM_W-1:0] dx;
		logic [DIM_W-1:0] dy;
		logic [DIM_W-1:0] dz;
		logic [VAR_W-1:0] nv;
		logic [OCT_W-1:0] oct;
	} obra_cfg_t;

	typedef struct packed {
		logic acc;
		logic adv_s1;
		logic load_s2;
		logic adv_s2;
	} obra_ctl_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] e;
		e = {d[DIM_W-1:1], 1'b0};
		if (e < DIM_W'(2)) begin
			e = DIM_W'(2);
		end else if (e > DIM_W'(MAX_DIM)) begin
			e = DIM_W'(MAX_DIM);
		end
		return e;
	endfunction

	function automatic logic [VAR_W-1:0] eff_vars(input logic [VAR_W-1:0] n);
		logic [VAR_W-1:0] e;
		e = n;
		if (e == '0) begin
			e = VAR_W'(1);
		end else if (e > VAR_W'(MAX_VARS)) begin
			e = VAR_W'(MAX_VARS);
		end
		return e;
	endfunction

endpackage

// File: rtl/core/obra_cfg.sv
// Configuration registers; dimensions and variable count are held in clamped form.
module obra_cfg import obra_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  idx,
	input  logic [CFG_DATA_W-1:0] wdata,
	output obra_cfg_t             cfg
);

	obra_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dx <= RST_DIM;
			cfg_q.dy <= RST_DIM;
			cfg_q.dz <= RST_DIM;
			cfg_q.nv <= RST_VARS;
			cfg_q.oct <= RST_OCT;
		end else if (we) begin
			unique case (idx)
				REG_DIM_X: begin
					cfg_q.dx <= eff_dim(wdata[DIM_W-1:0]);
				end
				REG_DIM_Y: begin
					cfg_q.dy <= eff_dim(wdata[DIM_W-1:0]);
				end
				REG_DIM_Z: begin
					cfg_q.dz <= eff_dim(wdata[DIM_W-1:0]);
				end
				REG_NUM_VARS: begin
					cfg_q.nv <= eff_vars(wdata[VAR_W-1:0]);
				end
				REG_OCTANT: begin
					cfg_q.oct <= wdata[OCT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/obra_sum.sv
// Partial-sum memory with read-modify-write accumulation and write forwarding.
module obra_sum import obra_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  obra_ctl_t                  ctl,
	input  logic [SLOT_W-1:0]          in_slot,
	input  logic                       in_wr,
	input  logic                       in_first,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	output logic [SUM_W-1:0]           sum
);

	logic [SUM_W-1:0] mem [SLOTS];

	logic [SUM_W-1:0]  rd_s1;
	logic [SUM_W-1:0]  fwd_s1;
	logic [SUM_W-1:0]  ext_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              first_s1;
	logic              wr_s1;
	logic              hit_s1;
	logic [SUM_W-1:0]  base;
	logic              hit_in;

	assign hit_in = ctl.adv_s1 && wr_s1 && (slot_s1 == in_slot);

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			rd_s1 <= mem[in_slot];
		end
		if (ctl.adv_s1 && wr_s1) begin
			mem[slot_s1] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			slot_s1 <= in_slot;
			first_s1 <= in_first;
			ext_s1 <= {{(SUM_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample};
			fwd_s1 <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else if (ctl.acc) begin
			wr_s1 <= in_wr;
			hit_s1 <= hit_in;
		end
	end

	// A write and a read of the same slot at one edge return the old word,
	// so the value being written is taken over instead.
	assign base = hit_s1 ? fwd_s1 : rd_s1;
	assign sum = first_s1 ? ext_s1 : (base + ext_s1);

endmodule

// File: rtl/core/obra_idx.sv
// Parent address pipeline: octant placement and the linear index, one multiply per stage.
module obra_idx import obra_pkg::*; (
	input  logic               clk,
	input  obra_cfg_t          cfg,
	input  obra_ctl_t          ctl,
	input  logic [CHILD_W-1:0] child,
	input  logic [FINE_W-1:0]  fx,
	input  logic [FINE_W-1:0]  fy,
	input  logic [FINE_W-1:0]  fz,
	input  logic [VAR_W-1:0]   var_i,
	output logic [TGT_W-1:0]   target
);

	logic [OCT_BITS-1:0]      oct_sel;
	logic [FINE_W-1:0]        cx;
	logic [FINE_W-1:0]        cy;
	logic [FINE_W-1:0]        cz;
	logic [FINE_W+DIM_W-1:0]  zy_prod;
	logic [A_W+DIM_W-1:0]     b_prod;
	logic [B_W+VAR_W-1:0]     t_prod;

	logic [A_W-1:0]    a_s1;
	logic [FINE_W-1:0] cx_s1;
	logic [VAR_W-1:0]  var_s1;
	logic [B_W-1:0]    b_s2;
	logic [VAR_W-1:0]  var_s2;
	logic [TGT_W-1:0]  target_q;

	always_comb begin
		oct_sel = cfg.oct[child * OCT_BITS +: OCT_BITS];
		cx = (oct_sel[0] ? cfg.dx[DIM_W-1:1] : '0) + {1'b0, fx[FINE_W-1:1]};
		cy = (oct_sel[1] ? cfg.dy[DIM_W-1:1] : '0) + {1'b0, fy[FINE_W-1:1]};
		cz = (oct_sel[2] ? cfg.dz[DIM_W-1:1] : '0) + {1'b0, fz[FINE_W-1:1]};
		zy_prod = {{DIM_W{1'b0}}, cz} * {{FINE_W{1'b0}}, cfg.dy};
		b_prod = {{DIM_W{1'b0}}, a_s1} * {{A_W{1'b0}}, cfg.dx};
		t_prod = {{VAR_W{1'b0}}, b_s2} * {{B_W{1'b0}}, cfg.nv};
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			a_s1 <= A_W'(zy_prod + (FINE_W + DIM_W)'(cy));
			cx_s1 <= cx;
			var_s1 <= var_i;
		end
		if (ctl.load_s2) begin
			b_s2 <= B_W'(b_prod + (A_W + DIM_W)'(cx_s1));
			var_s2 <= var_s1;
		end
		if (ctl.adv_s2) begin
			target_q <= TGT_W'(t_prod + (B_W + VAR_W)'(var_s2));
		end
	end

	assign target = target_q;

endmodule

// File: rtl/core/octree_block_restrict_avg.sv
// Top level of the 2x2x2 box-filter restriction of eight child blocks into a parent.
//
//  channel | direction | handshake                   | payload
//  s_*     | in        | s_tvalid / s_tready          | s_tdata: one fine sample
//  m_*     | out       | m_tvalid / m_tready          | m_tdata: parent index, average
//  cfg_*   | in        | cfg_we, no wait              | cfg_idx, cfg_wdata
//
// One sample is taken per cycle while s_tready is high; once its last corner is taken,
// a result passes stage 1, stage 2 and the output register.  The partial-sum memory
// has one read and one write port: read at the input transfer, written as stage 1 advances.
// Reset clears control and configuration only; the memory is not cleared.
// s_tready drops only while a last-corner sample waits with both later stages full.
module octree_block_restrict_avg import obra_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// child_index, fine_x, fine_y, fine_z, var_index, sample, zero fill
	input  logic [IN_W-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// target_index, average, zero fill
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	obra_cfg_t cfg;
	obra_ctl_t ctl;

	logic [CHILD_W-1:0]         child;
	logic [FINE_W-1:0]          fx;
	logic [FINE_W-1:0]          fy;
	logic [FINE_W-1:0]          fz;
	logic [VAR_W-1:0]           var_i;
	logic signed [SAMPLE_W-1:0] sample;

	logic              in_ok;
	logic              in_first;
	logic              in_last;
	logic [SLOT_W-1:0] in_slot;
	logic [SUM_W-1:0]  sum;
	logic [TGT_W-1:0]  target;

	logic vld_s1;
	logic emit_s1;
	logic vld_s2;
	logic out_vld_q;
	logic out_free;
	logic s2_free;

	logic [SAMPLE_W-1:0] avg_s2;
	logic [SAMPLE_W-1:0] avg_q;

	assign child = s_tdata[CHILD_W-1:0];
	assign fx = s_tdata[CHILD_W +: FINE_W];
	assign fy = s_tdata[CHILD_W + FINE_W +: FINE_W];
	assign fz = s_tdata[CHILD_W + 2 * FINE_W +: FINE_W];
	assign var_i = s_tdata[CHILD_W + 3 * FINE_W +: VAR_W];
	assign sample = s_tdata[CHILD_W + 3 * FINE_W + VAR_W +: SAMPLE_W];

	always_comb begin
		in_ok = ({1'b0, fx} < cfg.dx) && ({1'b0, fy} < cfg.dy) && ({1'b0, fz} < cfg.dz)
			&& (var_i < cfg.nv);
		in_first = !(fx[0] || fy[0] || fz[0]);
		in_last = fx[0] && fy[0] && fz[0];
		in_slot = SLOT_W'((SLOT_W'(fy[FINE_W-1:1]) * SLOT_W'(HALF_MAX)
			+ SLOT_W'(fx[FINE_W-1:1])) * SLOT_W'(MAX_VARS) + SLOT_W'(var_i));
	end

	always_comb begin
		out_free = !out_vld_q || m_tready;
		s2_free = !vld_s2 || out_free;
		ctl.adv_s1 = vld_s1 && (!emit_s1 || s2_free);
		s_tready = !vld_s1 || ctl.adv_s1;
		ctl.acc = s_tvalid && s_tready;
		ctl.load_s2 = ctl.adv_s1 && emit_s1;
		ctl.adv_s2 = vld_s2 && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ctl.acc) begin
				vld_s1 <= 1'b1;
				emit_s1 <= in_ok && in_last;
			end else if (ctl.adv_s1) begin
				vld_s1 <= 1'b0;
			end
			vld_s2 <= ctl.load_s2 || (vld_s2 && !ctl.adv_s2);
			out_vld_q <= ctl.adv_s2 || (out_vld_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			avg_s2 <= sum[SUM_W-1:SUM_W-SAMPLE_W];
		end
		if (ctl.adv_s2) begin
			avg_q <= avg_s2;
		end
	end

	obra_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	obra_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.in_slot   (in_slot),
		.in_wr     (in_ok),
		.in_first  (in_first),
		.in_sample (sample),
		.sum       (sum)
	);

	obra_idx u_idx (
		.clk    (clk),
		.cfg    (cfg),
		.ctl    (ctl),
		.child  (child),
		.fx     (fx),
		.fy     (fy),
		.fz     (fz),
		.var_i  (var_i),
		.target (target)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, avg_q, target};

endmodule

// File: rtl/core/obra_chk.sv
// Port-level checks of the restriction averager, bound to its top level.
module obra_chk import obra_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_W-1:0]       s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_W-1:0]      m_tdata,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);

	// With the output register empty nothing can block the input side.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or vanished");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TGT_W-1:0] <= TGT_MAX) && !m_tdata[OUT_W-1])
		else $error("parent index out of range or fill bit set");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result shown during reset");

endmodule

bind octree_block_restrict_avg obra_chk u_obra_chk (.*);
